// ===== rtl/rmbp_pkg.sv =====
`timescale 1ns / 1ps

package rmbp_pkg;

    // Field and state widths
    localparam int COUNT_BITS  = 21;
    localparam int LENGTH_BITS = 31;
    localparam int INDEX_BITS  = 20;
    localparam int ACC_BITS    = 32;

    // Result kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_DATA = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;
    localparam logic [1:0] KIND_ERR  = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_PREFIX = 3'd1;
    localparam logic [2:0] ERR_NUMBER = 3'd2;
    localparam logic [2:0] ERR_LIMIT  = 3'd3;
    localparam logic [2:0] ERR_CRLF   = 3'd4;

    // Configuration register indexes
    localparam logic CFG_MAX_ARG_COUNT  = 1'b0;
    localparam logic CFG_MAX_ARG_LENGTH = 1'b1;

    // Reset values of the limits
    localparam logic [COUNT_BITS-1:0]  MAX_COUNT_RESET  = COUNT_BITS'(1024);
    localparam logic [LENGTH_BITS-1:0] MAX_LENGTH_RESET = LENGTH_BITS'(536870912);

    // Protocol characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    typedef enum logic [12:0] {
        PH_IDLE       = 13'b0000000000001,
        PH_CNT_START  = 13'b0000000000010,
        PH_CNT_SIGNED = 13'b0000000000100,
        PH_CNT_DIGITS = 13'b0000000001000,
        PH_CNT_LF     = 13'b0000000010000,
        PH_BULK       = 13'b0000000100000,
        PH_LEN_START  = 13'b0000001000000,
        PH_LEN_SIGNED = 13'b0000010000000,
        PH_LEN_DIGITS = 13'b0000100000000,
        PH_LEN_LF     = 13'b0001000000000,
        PH_DATA       = 13'b0010000000000,
        PH_DCR        = 13'b0100000000000,
        PH_DLF        = 13'b1000000000000
    } phase_t;

    typedef struct packed {
        phase_t                  phase;
        logic [COUNT_BITS-1:0]   args_remaining;
        logic [LENGTH_BITS-1:0]  bytes_remaining;
        logic [ACC_BITS-1:0]     number_accumulator;
        logic                    number_negative;
        logic [INDEX_BITS-1:0]   current_arg;
    } parse_state_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [7:0]             data_byte;
        logic [INDEX_BITS-1:0]  arg_index;
        logic                   last_of_arg;
        logic [2:0]             error_code;
    } parse_result_t;

    localparam parse_state_t STATE_RESET = '{
        phase:              PH_IDLE,
        args_remaining:     '0,
        bytes_remaining:    '0,
        number_accumulator: '0,
        number_negative:    1'b0,
        current_arg:        '0
    };

endpackage

// ===== rtl/resp_multibulk_request_parser_core.sv =====
`timescale 1ns / 1ps

// RESP multibulk request parser.
// Input channel (in_valid, in_stall, in_byte) carries the raw request stream,
// one byte per transaction. Output channel (out_valid, out_stall, kind,
// data_byte, arg_index, last_of_arg, error_code) carries exactly one result
// per input byte: nothing, an argument data byte, request complete, or an
// error with its code. After an error the parser is back at idle.
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// max_arg_count (index 0) and max_arg_length (index 1); cfg_ready is always
// high. Write it only while the parser is idle.
// A byte taken into the input register is parsed into the result register,
// whose contents are on the output ports. Throughput: one byte per cycle
// while out_stall is low; the parser state update is a combinational step
// between the input register and the result register.
// When out_stall is high with a result pending, the input register still
// takes one more byte; in_stall rises once both registers are full.
// Reset clears the parser to idle and loads the default limits (1024 args,
// 536870912 bytes per argument).
module resp_multibulk_request_parser_core
    import rmbp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               in_byte,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               kind,
    output logic [7:0]               data_byte,
    output logic [INDEX_BITS-1:0]    arg_index,
    output logic                     last_of_arg,
    output logic [2:0]               error_code,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic                     cfg_index,
    input  logic [LENGTH_BITS-1:0]   cfg_data
);

    logic                     in_full_reg;
    logic [7:0]               in_byte_reg;
    logic                     out_valid_reg;
    parse_result_t            result_reg;
    parse_result_t            result_next;
    parse_state_t             state_reg;
    parse_state_t             state_next;
    logic [COUNT_BITS-1:0]    max_count_reg;
    logic [LENGTH_BITS-1:0]   max_length_reg;
    logic                     advance;
    logic                     accept;

    // Move a byte forward when the result register is free or being drained
    assign advance   = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    rmbp_step u_step (
        .state          (state_reg),
        .in_byte        (in_byte_reg),
        .max_arg_count  (max_count_reg),
        .max_arg_length (max_length_reg),
        .state_next     (state_next),
        .result         (result_next)
    );

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (accept)
            in_full_reg <= 1'b1;
        else if (advance)
            in_full_reg <= 1'b0;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
            in_byte_reg <= in_byte;
    end

    // Parser state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_count_reg  <= MAX_COUNT_RESET;
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_ARG_COUNT:  max_count_reg  <= cfg_data[COUNT_BITS-1:0];
                CFG_MAX_ARG_LENGTH: max_length_reg <= cfg_data;
                default:            max_count_reg  <= max_count_reg;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = result_reg.kind;
    assign data_byte   = result_reg.data_byte;
    assign arg_index   = result_reg.arg_index;
    assign last_of_arg = result_reg.last_of_arg;
    assign error_code  = result_reg.error_code;

endmodule

// ===== rtl/rmbp_step.sv =====
`timescale 1ns / 1ps

module rmbp_step
    import rmbp_pkg::*;
(
    input  parse_state_t             state,
    input  logic [7:0]               in_byte,
    input  logic [COUNT_BITS-1:0]    max_arg_count,
    input  logic [LENGTH_BITS-1:0]   max_arg_length,
    output parse_state_t             state_next,
    output parse_result_t            result
);

    logic                 is_digit;
    logic                 is_sign;
    logic [3:0]           digit_val;
    logic [ACC_BITS+3:0]  acc_times_ten;
    logic [ACC_BITS-1:0]  acc_sat;
    logic                 num_zero_or_neg;
    logic                 count_over;
    logic                 length_over;
    parse_state_t         nxt;
    logic [1:0]           kind;
    logic [2:0]           err;
    logic [7:0]           data;
    logic                 last;

    // Classify the byte
    assign is_digit  = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign is_sign   = (in_byte == CH_PLUS) || (in_byte == CH_MINUS);
    assign digit_val = 4'(in_byte - CH_ZERO);

    // Decimal accumulate step, saturating at the accumulator width
    assign acc_times_ten = ({4'b0, state.number_accumulator} << 3)
                         + ({4'b0, state.number_accumulator} << 1)
                         + {{ACC_BITS{1'b0}}, digit_val};
    assign acc_sat = (acc_times_ten[ACC_BITS+3:ACC_BITS] != 4'b0)
                   ? {ACC_BITS{1'b1}} : acc_times_ten[ACC_BITS-1:0];

    // Checks on a completed number
    assign num_zero_or_neg = state.number_negative || (state.number_accumulator == '0);
    assign count_over  = state.number_accumulator
                       > {{(ACC_BITS-COUNT_BITS){1'b0}}, max_arg_count};
    assign length_over = state.number_accumulator
                       > {{(ACC_BITS-LENGTH_BITS){1'b0}}, max_arg_length};

    // Advance the parser by one byte
    always_comb
    begin
        nxt  = state;
        kind = KIND_NONE;
        err  = ERR_NONE;
        data = 8'd0;
        last = 1'b0;

        case (state.phase)
            PH_IDLE:
            begin
                if (in_byte == CH_STAR)
                begin
                    nxt.number_accumulator = '0;
                    nxt.number_negative    = 1'b0;
                    nxt.phase              = PH_CNT_START;
                end
                else
                    err = ERR_PREFIX;
            end
            PH_CNT_START, PH_LEN_START:
            begin
                if (is_sign)
                begin
                    nxt.number_negative = (in_byte == CH_MINUS);
                    nxt.phase = (state.phase == PH_CNT_START) ? PH_CNT_SIGNED : PH_LEN_SIGNED;
                end
                else if (!is_digit)
                    err = ERR_NUMBER;
                else
                begin
                    nxt.number_accumulator = {{(ACC_BITS-4){1'b0}}, digit_val};
                    nxt.phase = (state.phase == PH_CNT_START) ? PH_CNT_DIGITS : PH_LEN_DIGITS;
                end
            end
            PH_CNT_SIGNED, PH_LEN_SIGNED:
            begin
                if (!is_digit)
                    err = ERR_NUMBER;
                else
                begin
                    nxt.number_accumulator = {{(ACC_BITS-4){1'b0}}, digit_val};
                    nxt.phase = (state.phase == PH_CNT_SIGNED) ? PH_CNT_DIGITS : PH_LEN_DIGITS;
                end
            end
            PH_CNT_DIGITS, PH_LEN_DIGITS:
            begin
                if (is_digit)
                    nxt.number_accumulator = acc_sat;
                else if (in_byte == CH_CR)
                    nxt.phase = (state.phase == PH_CNT_DIGITS) ? PH_CNT_LF : PH_LEN_LF;
                else
                    err = ERR_NUMBER;
            end
            PH_CNT_LF:
            begin
                if (in_byte != CH_LF)
                    err = ERR_CRLF;
                else if (num_zero_or_neg)
                begin
                    kind = KIND_DONE;
                    nxt  = STATE_RESET;
                end
                else if (count_over)
                    err = ERR_LIMIT;
                else
                begin
                    nxt.args_remaining = state.number_accumulator[COUNT_BITS-1:0];
                    nxt.current_arg    = '0;
                    nxt.phase          = PH_BULK;
                end
            end
            PH_BULK:
            begin
                if (in_byte == CH_DOLLAR)
                begin
                    nxt.number_accumulator = '0;
                    nxt.number_negative    = 1'b0;
                    nxt.phase              = PH_LEN_START;
                end
                else
                    err = ERR_PREFIX;
            end
            PH_LEN_LF:
            begin
                if (in_byte != CH_LF)
                    err = ERR_CRLF;
                else if (num_zero_or_neg)
                begin
                    kind = KIND_DONE;
                    nxt  = STATE_RESET;
                end
                else if (length_over)
                    err = ERR_LIMIT;
                else
                begin
                    nxt.bytes_remaining = state.number_accumulator[LENGTH_BITS-1:0];
                    nxt.phase           = PH_DATA;
                end
            end
            PH_DATA:
            begin
                kind = KIND_DATA;
                data = in_byte;
                if (state.bytes_remaining <= LENGTH_BITS'(1))
                begin
                    last                = 1'b1;
                    nxt.bytes_remaining = '0;
                    nxt.phase           = PH_DCR;
                end
                else
                    nxt.bytes_remaining = state.bytes_remaining - LENGTH_BITS'(1);
            end
            PH_DCR:
            begin
                if (in_byte == CH_CR)
                    nxt.phase = PH_DLF;
                else
                    err = ERR_CRLF;
            end
            PH_DLF:
            begin
                if (in_byte != CH_LF)
                    err = ERR_CRLF;
                else if (state.args_remaining <= COUNT_BITS'(1))
                begin
                    kind = KIND_DONE;
                    nxt  = STATE_RESET;
                end
                else
                begin
                    nxt.args_remaining = state.args_remaining - COUNT_BITS'(1);
                    nxt.current_arg    = state.current_arg + INDEX_BITS'(1);
                    nxt.phase          = PH_BULK;
                end
            end
            default:
            begin
                nxt = STATE_RESET;
            end
        endcase

        // Drop back to idle on any protocol fault
        if (err != ERR_NONE)
        begin
            kind = KIND_ERR;
            nxt  = STATE_RESET;
        end
    end

    assign state_next         = nxt;
    assign result.kind        = kind;
    assign result.data_byte   = data;
    assign result.arg_index   = state.current_arg;
    assign result.last_of_arg = last;
    assign result.error_code  = err;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rmbp_pkg::*;

    // Byte that forces any header or trailer phase back to idle
    localparam logic [7:0] FLUSH_BYTE = 8'h58;
    localparam int SEGMENT_BYTES = 130;

    // Expected parser results, one per accepted byte, in arrival order
    class parse_scoreboard;
        phase_t                 phase;
        logic [COUNT_BITS-1:0]  args_left;
        logic [LENGTH_BITS-1:0] bytes_left;
        logic [ACC_BITS-1:0]    acc;
        logic                   negative;
        logic [INDEX_BITS-1:0]  arg_cur;
        logic [COUNT_BITS-1:0]  count_limit;
        logic [LENGTH_BITS-1:0] length_limit;
        parse_result_t          expected_results[$];
        int mismatches;
        int checked;
        int data_bytes;
        int requests_done;
        int protocol_errors;

        function new();
            count_limit = MAX_COUNT_RESET;
            length_limit = MAX_LENGTH_RESET;
            clear_parse();
        endfunction

        function void clear_parse();
            phase = PH_IDLE;
            args_left = '0;
            bytes_left = '0;
            acc = '0;
            negative = 1'b0;
            arg_cur = '0;
        endfunction

        function void set_limit(logic idx, logic [LENGTH_BITS-1:0] value);
            if (idx == CFG_MAX_ARG_COUNT)
                count_limit = value[COUNT_BITS-1:0];
            else
                length_limit = value;
        endfunction

        // Advance one step of a decimal field (count or length)
        function void number_step(input logic [7:0] b, input bit is_len,
                                  output logic [2:0] err, output bit complete);
            bit digit;
            logic [63:0] wide;
            digit = (b >= CH_ZERO) && (b <= CH_NINE);
            err = ERR_NONE;
            complete = 1'b0;
            case (phase)
                PH_CNT_START, PH_LEN_START, PH_CNT_SIGNED, PH_LEN_SIGNED:
                begin
                    if ((phase == PH_CNT_START || phase == PH_LEN_START) &&
                        (b == CH_MINUS || b == CH_PLUS))
                    begin
                        negative = (b == CH_MINUS);
                        phase = is_len ? PH_LEN_SIGNED : PH_CNT_SIGNED;
                    end
                    else if (!digit)
                        err = ERR_NUMBER;
                    else
                    begin
                        acc = {24'd0, b - CH_ZERO};
                        phase = is_len ? PH_LEN_DIGITS : PH_CNT_DIGITS;
                    end
                end
                PH_CNT_DIGITS, PH_LEN_DIGITS:
                begin
                    if (digit)
                    begin
                        // Saturate the accumulator at all ones
                        wide = {32'd0, acc} * 64'd10 + {56'd0, b - CH_ZERO};
                        acc = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
                    end
                    else if (b == CH_CR)
                        phase = is_len ? PH_LEN_LF : PH_CNT_LF;
                    else
                        err = ERR_NUMBER;
                end
                default:
                begin
                    if (b != CH_LF)
                        err = ERR_CRLF;
                    else
                        complete = 1'b1;
                end
            endcase
        endfunction

        // Predict the result of one accepted byte and queue it
        function void note_byte(logic [7:0] b);
            parse_result_t r;
            logic [2:0] e;
            bit complete;
            r.kind = KIND_NONE;
            r.data_byte = 8'd0;
            r.arg_index = arg_cur;
            r.last_of_arg = 1'b0;
            r.error_code = ERR_NONE;
            case (phase)
                PH_IDLE:
                begin
                    if (b == CH_STAR)
                    begin
                        acc = '0;
                        negative = 1'b0;
                        phase = PH_CNT_START;
                    end
                    else
                        r.error_code = ERR_PREFIX;
                end
                PH_CNT_START, PH_CNT_SIGNED, PH_CNT_DIGITS, PH_CNT_LF:
                begin
                    number_step(b, 1'b0, e, complete);
                    if (e != ERR_NONE)
                        r.error_code = e;
                    else if (complete)
                    begin
                        if (negative || acc == 0)
                        begin
                            r.kind = KIND_DONE;
                            clear_parse();
                        end
                        else if (acc > {11'd0, count_limit})
                            r.error_code = ERR_LIMIT;
                        else
                        begin
                            args_left = acc[COUNT_BITS-1:0];
                            arg_cur = '0;
                            phase = PH_BULK;
                        end
                    end
                end
                PH_BULK:
                begin
                    if (b == CH_DOLLAR)
                    begin
                        acc = '0;
                        negative = 1'b0;
                        phase = PH_LEN_START;
                    end
                    else
                        r.error_code = ERR_PREFIX;
                end
                PH_LEN_START, PH_LEN_SIGNED, PH_LEN_DIGITS, PH_LEN_LF:
                begin
                    number_step(b, 1'b1, e, complete);
                    if (e != ERR_NONE)
                        r.error_code = e;
                    else if (complete)
                    begin
                        if (negative || acc == 0)
                        begin
                            r.kind = KIND_DONE;
                            clear_parse();
                        end
                        else if (acc > {1'b0, length_limit})
                            r.error_code = ERR_LIMIT;
                        else
                        begin
                            bytes_left = acc[LENGTH_BITS-1:0];
                            phase = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    r.kind = KIND_DATA;
                    r.data_byte = b;
                    if (bytes_left <= 1)
                    begin
                        r.last_of_arg = 1'b1;
                        bytes_left = '0;
                        phase = PH_DCR;
                    end
                    else
                        bytes_left = bytes_left - 1'b1;
                end
                PH_DCR:
                begin
                    if (b == CH_CR)
                        phase = PH_DLF;
                    else
                        r.error_code = ERR_CRLF;
                end
                PH_DLF:
                begin
                    if (b != CH_LF)
                        r.error_code = ERR_CRLF;
                    else if (args_left <= 1)
                    begin
                        r.kind = KIND_DONE;
                        clear_parse();
                    end
                    else
                    begin
                        args_left = args_left - 1'b1;
                        arg_cur = arg_cur + 1'b1;
                        phase = PH_BULK;
                    end
                end
                default:
                    clear_parse();
            endcase
            // Any fault drops the request and resynchronizes
            if (r.error_code != ERR_NONE)
            begin
                r.kind = KIND_ERR;
                clear_parse();
            end
            case (r.kind)
                KIND_DATA: data_bytes++;
                KIND_DONE: requests_done++;
                KIND_ERR:  protocol_errors++;
                default: ;
            endcase
            expected_results.push_back(r);
        endfunction

        task report(string what);
            $display("MISMATCH at result %0d: %s", checked, what);
            mismatches++;
        endtask

        // Compare one result transaction with the oldest expectation
        task check_result(parse_result_t got);
            parse_result_t want;
            if (expected_results.size() == 0)
            begin
                report($sformatf("unexpected result kind %0d", got.kind));
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.data_byte !== want.data_byte)
                report($sformatf("data_byte %0h, expected %0h",
                                 got.data_byte, want.data_byte));
            if (got.arg_index !== want.arg_index)
                report($sformatf("arg_index %0d, expected %0d",
                                 got.arg_index, want.arg_index));
            if (got.last_of_arg !== want.last_of_arg)
                report($sformatf("last_of_arg %0b, expected %0b",
                                 got.last_of_arg, want.last_of_arg));
            if (got.error_code !== want.error_code)
                report($sformatf("error_code %0d, expected %0d",
                                 got.error_code, want.error_code));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             in_byte = 8'd0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [1:0]             kind;
    logic [7:0]             data_byte;
    logic [INDEX_BITS-1:0]  arg_index;
    logic                   last_of_arg;
    logic [2:0]             error_code;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = CFG_MAX_ARG_COUNT;
    logic [LENGTH_BITS-1:0] cfg_data = '0;

    parse_scoreboard sb = new();
    logic [7:0] request_bytes[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int limit_settings = 1;

    resp_multibulk_request_parser_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .arg_index   (arg_index),
        .last_of_arg (last_of_arg),
        .error_code  (error_code),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Check result transactions and drive random backpressure
    always @(posedge clk)
    begin : watch_results
        parse_result_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got.kind = kind;
                got.data_byte = data_byte;
                got.arg_index = arg_index;
                got.last_of_arg = last_of_arg;
                got.error_code = error_code;
                sb.check_result(got);
            end
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Send one byte, with random idle cycles ahead of it
    task send_byte(logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(b);
    endtask

    task write_limit(logic idx, logic [LENGTH_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_limit(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Return the parser to idle and let every result drain
    task settle();
        while (sb.phase != PH_IDLE)
            send_byte(sb.phase == PH_DATA ? 8'($urandom_range(0, 255)) : FLUSH_BYTE);
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            request_bytes.push_back(s[i]);
    endfunction

    function void add_line(string s);
        add_text(s);
        request_bytes.push_back(CH_CR);
        request_bytes.push_back(CH_LF);
    endfunction

    // Decimal text, now and then with a plus sign or a leading zero
    function string num_text(longint unsigned v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 7) == 0)
            s = {"0", s};
        if ($urandom_range(0, 7) == 0)
            s = {"+", s};
        return s;
    endfunction

    // Digits enough to saturate the accumulator
    function string huge_digits();
        string s;
        s = $sformatf("%0d", $urandom_range(1, 9));
        repeat ($urandom_range(10, 12))
            s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        return s;
    endfunction

    function void add_wellformed();
        int nargs;
        int len;
        nargs = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : $urandom_range(1, 3);
        add_line({"*", num_text(nargs)});
        repeat (nargs)
        begin
            len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 8);
            add_line({"$", num_text(len)});
            repeat (len)
                request_bytes.push_back(8'($urandom_range(0, 255)));
            add_line("");
        end
    endfunction

    // Append one random request: mostly well formed, some broken or noise
    function void add_request();
        int pick;
        int pos;
        int start;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            add_wellformed();
        else if (pick < 75)
        begin
            case ($urandom_range(0, 4))
                0: add_line("*0");
                1: add_line({"*-", num_text($urandom_range(0, 99))});
                2: add_line({"*-", huge_digits()});
                3: begin add_line("*1"); add_line("$0"); end
                default: begin add_line("*2"); add_line("$-1"); end
            endcase
        end
        else if (pick < 85)
        begin
            // Corrupt one byte of a good request
            start = request_bytes.size();
            add_wellformed();
            pos = $urandom_range(start, request_bytes.size() - 1);
            request_bytes[pos] = 8'($urandom_range(0, 255));
        end
        else if (pick < 93)
        begin
            case ($urandom_range(0, 3))
                0: add_line({"*", $sformatf("%0d", longint'(sb.count_limit) + 1 +
                                                  $urandom_range(0, 1000))});
                1: add_line({"*", huge_digits()});
                2:
                begin
                    add_line("*1");
                    add_line({"$", $sformatf("%0d", longint'(sb.length_limit) + 1 +
                                                    $urandom_range(0, 1000))});
                end
                default:
                begin
                    add_line("*1");
                    add_line({"$", huge_digits()});
                end
            endcase
        end
        else
            repeat ($urandom_range(1, 4))
                request_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task run_segment();
        while (request_bytes.size() < SEGMENT_BYTES)
            add_request();
        while (request_bytes.size() != 0)
            send_byte(request_bytes.pop_front());
    endtask

    task new_limits(logic [COUNT_BITS-1:0] count, logic [LENGTH_BITS-1:0] length);
        settle();
        write_limit(CFG_MAX_ARG_COUNT, {10'd0, count});
        write_limit(CFG_MAX_ARG_LENGTH, length);
        limit_settings++;
    endtask

    initial
    begin : stimulus
        wait (rst_n === 1'b1);
        @(posedge clk);
        send_idle_pct = 26;
        recv_idle_pct = 52;

        // Directed: zero and negative counts, idle prefix fault, a one-byte
        // argument, and a sign with no digits
        add_line("*0");
        request_bytes.push_back(8'h00);
        add_line("*1");
        add_line("$1");
        request_bytes.push_back(8'hFF);
        add_line("");
        add_line("*-1");
        add_text("*+");
        request_bytes.push_back(CH_CR);
        run_segment();

        new_limits(21'd1, 31'd1);
        run_segment();

        send_idle_pct = 52;
        recv_idle_pct = 26;
        new_limits(21'd1048576, 31'h7FFF_FFFF);
        run_segment();
        new_limits(21'($urandom_range(1, 1048576)), 31'($urandom_range(1, 32'h7FFF_FFFF)));
        run_segment();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        new_limits(21'd3, 31'd5);
        run_segment();
        new_limits(MAX_COUNT_RESET, MAX_LENGTH_RESET);
        run_segment();

        settle();
        repeat (8) @(posedge clk);
        $display("Parsed %0d stream bytes across %0d limit settings and three stall mixes",
                 sb.checked, limit_settings);
        $display("Saw %0d argument bytes, %0d complete requests, %0d protocol errors",
                 sb.data_bytes, sb.requests_done, sb.protocol_errors);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rmbp_pkg.sv
rtl/rmbp_step.sv
rtl/resp_multibulk_request_parser_core.sv
sim/testbench.sv
